@@ sv/risc16_instruction_executor_macros.svh @@
// ----------------------------------------------------------------------------
// risc16_instruction_executor_macros.svh
// Assertion macros shared by the checker of the instruction executor.
// ----------------------------------------------------------------------------
`ifndef RISC16_INSTRUCTION_EXECUTOR_MACROS_SVH
`define RISC16_INSTRUCTION_EXECUTOR_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low
`define R16IE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low
`define R16IE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/r16ie_pkg.sv @@
// ----------------------------------------------------------------------------
// r16ie_pkg
// Types, opcodes and constants of the 16-bit RISC instruction executor.
// ----------------------------------------------------------------------------
package r16ie_pkg;

    localparam int MEM_ADDR_BITS = 16;
    localparam int REG_COUNT     = 32;
    localparam int REG_IDX_W     = 5;
    localparam int DATA_W        = 16;

    localparam logic [REG_IDX_W-1:0] SP_REG   = 5'd29;
    localparam logic [REG_IDX_W-1:0] LINK_REG = 5'd31;
    localparam logic [REG_IDX_W-1:0] ZERO_REG = 5'd0;

    localparam logic [DATA_W-1:0] STACK_INIT_RESET = 16'h3400;
    localparam logic [DATA_W-1:0] PC_STEP          = 16'd4;

    typedef enum logic [4:0] {
        OP_ORI    = 5'd0,
        OP_ADDI   = 5'd1,
        OP_BEQ    = 5'd2,
        OP_BNE    = 5'd3,
        OP_SB     = 5'd4,
        OP_LBU    = 5'd5,
        OP_JAL    = 5'd6,
        OP_LW     = 5'd7,
        OP_SW     = 5'd8,
        OP_J      = 5'd9,
        OP_NOR    = 5'd10,
        OP_SLT    = 5'd11,
        OP_SLL    = 5'd12,
        OP_SRA    = 5'd13,
        OP_JR     = 5'd14,
        OP_SRL    = 5'd15,
        OP_OR     = 5'd16,
        OP_SUB    = 5'd17,
        OP_ADD    = 5'd18,
        OP_AND    = 5'd19,
        OP_SET_PC = 5'd20
    } op_t;

    // Input beat, last field in the low bits
    typedef struct packed {
        logic [DATA_W-1:0]    imm_value;
        logic [3:0]           shift_amount;
        logic [REG_IDX_W-1:0] dst_c;
        logic [REG_IDX_W-1:0] src_b;
        logic [REG_IDX_W-1:0] src_a;
        op_t                  op;
    } inst_t;

    // Result beat, last field in the low bits
    typedef struct packed {
        logic                 halted;
        logic                 bad_op;
        logic [DATA_W-1:0]    written_value;
        logic [REG_IDX_W-1:0] dest_index;
        logic                 reg_written;
        logic [DATA_W-1:0]    next_pc;
    } res_t;

    localparam int IN_W  = $bits(inst_t);
    localparam int OUT_W = $bits(res_t);

    // Register file write request
    typedef struct packed {
        logic                 en;
        logic [REG_IDX_W-1:0] idx;
        logic [DATA_W-1:0]    data;
    } rf_wr_t;

    // Data memory request
    typedef struct packed {
        logic                     wr_byte;
        logic                     wr_word;
        logic [MEM_ADDR_BITS-1:0] addr;
        logic [DATA_W-1:0]        data;
    } dmem_req_t;

    // Second stage: result plus pending load kind
    typedef struct packed {
        logic ld_byte;
        logic ld_word;
        res_t res;
    } s2_t;

endpackage

@@ sv/risc16_instruction_executor.sv @@
// A result beat passes the stage-one, stage-two and output registers before it shows on m_tvalid.
// Throughput: one instruction per cycle while the skid register is empty; stage one reads the register file RAM,
// stage two reads or writes the data memory banks, a skid register buffers the output.
// Reset clears pc, pipeline valids and register valid bits, and sets stack_init to 0x3400.
// Data memory is not cleared; no clearing pass runs after reset.
// ----------------------------------------------------------------------------
// risc16_instruction_executor
// Two-stage executor of decoded 16-bit RISC instructions with skid output.
// ----------------------------------------------------------------------------
module risc16_instruction_executor (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // op, src_a, src_b, dst_c, shift_amount, imm_value
    input  logic [r16ie_pkg::IN_W-1:0]    s_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [r16ie_pkg::DATA_W-1:0]  cfg_data,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // next_pc, reg_written, dest_index, written_value, bad_op, halted
    output logic [r16ie_pkg::OUT_W-1:0]   m_tdata
);

    logic                          pipe_en;
    logic                          in_fire;
    logic                          cfg_we;

    logic                          s1_valid_reg;
    r16ie_pkg::inst_t              s1_reg;
    logic                          s2_valid_reg;
    r16ie_pkg::s2_t                s2_reg;
    r16ie_pkg::s2_t                s2_next;
    logic [r16ie_pkg::DATA_W-1:0]  pc_reg;

    logic [r16ie_pkg::DATA_W-1:0]  rf_a;
    logic [r16ie_pkg::DATA_W-1:0]  rf_b;
    logic [r16ie_pkg::DATA_W-1:0]  op_a;
    logic [r16ie_pkg::DATA_W-1:0]  op_b;
    r16ie_pkg::rf_wr_t             rf_wr;
    r16ie_pkg::dmem_req_t          dmem_req;
    logic [r16ie_pkg::DATA_W-1:0]  ld_word;
    r16ie_pkg::res_t               s2_res;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    r16ie_pkg::res_t               out_data_reg;
    logic                          skid_valid_reg;
    logic                          skid_valid_next;
    r16ie_pkg::res_t               skid_data_reg;
    logic                          out_take;
    logic                          s2_fire;

    // Advance the whole pipeline unless the skid register is occupied
    assign pipe_en   = !skid_valid_reg;
    assign s_tready  = pipe_en;
    assign in_fire   = s_tvalid && pipe_en;
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid;

    r16ie_regfile u_regfile (
        .clk      (clk),
        .rst_n    (rst_n),
        .re       (pipe_en),
        .ra_idx   (s_tdata[9:5]),
        .rb_idx   (s_tdata[14:10]),
        .wr       (rf_wr),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .a_data   (rf_a),
        .b_data   (rf_b)
    );

    // Stage two result with load data merged in
    always_comb
    begin
        s2_res = s2_reg.res;
        if (s2_reg.ld_word)
        begin
            s2_res.written_value = s2_reg.res.reg_written ? ld_word : '0;
        end
        else if (s2_reg.ld_byte)
        begin
            s2_res.written_value = s2_reg.res.reg_written ? {8'h00, ld_word[7:0]} : '0;
        end
    end

    // Write back from stage two
    always_comb
    begin
        rf_wr.en   = pipe_en && s2_valid_reg && s2_res.reg_written;
        rf_wr.idx  = s2_res.dest_index;
        rf_wr.data = s2_res.written_value;
    end

    // Forward the stage-two result into stage-one operands
    always_comb
    begin
        op_a = rf_a;
        op_b = rf_b;
        if (s2_valid_reg && s2_res.reg_written && (s2_res.dest_index == s1_reg.src_a))
        begin
            op_a = s2_res.written_value;
        end
        if (s2_valid_reg && s2_res.reg_written && (s2_res.dest_index == s1_reg.src_b))
        begin
            op_b = s2_res.written_value;
        end
    end

    // Stage one execute: ALU, branch target, memory request
    always_comb
    begin
        logic [r16ie_pkg::DATA_W-1:0]    imm;
        logic [r16ie_pkg::DATA_W-1:0]    pc4;
        logic [r16ie_pkg::DATA_W-1:0]    npc;
        logic [r16ie_pkg::DATA_W-1:0]    addr;
        logic [r16ie_pkg::DATA_W-1:0]    val;
        logic [r16ie_pkg::REG_IDX_W-1:0] dest;
        logic                            wr;
        logic                            bad;
        logic                            ld_b;
        logic                            ld_w;
        logic                            st_b;
        logic                            st_w;

        imm  = s1_reg.imm_value;
        pc4  = pc_reg + r16ie_pkg::PC_STEP;
        npc  = pc4;
        addr = op_a + imm;
        val  = '0;
        dest = s1_reg.src_b;
        wr   = 1'b0;
        bad  = 1'b0;
        ld_b = 1'b0;
        ld_w = 1'b0;
        st_b = 1'b0;
        st_w = 1'b0;

        unique case (s1_reg.op)
            r16ie_pkg::OP_ORI:
            begin
                wr  = 1'b1;
                val = op_a | imm;
            end
            r16ie_pkg::OP_ADDI:
            begin
                wr  = 1'b1;
                val = addr;
            end
            r16ie_pkg::OP_BEQ:
            begin
                if (op_a == op_b)
                begin
                    npc = pc4 + {imm[13:0], 2'b00};
                end
            end
            r16ie_pkg::OP_BNE:
            begin
                if (op_a != op_b)
                begin
                    npc = pc4 + {imm[13:0], 2'b00};
                end
            end
            r16ie_pkg::OP_SB:
            begin
                st_b = 1'b1;
            end
            r16ie_pkg::OP_LBU:
            begin
                wr   = 1'b1;
                ld_b = 1'b1;
            end
            r16ie_pkg::OP_JAL:
            begin
                wr   = 1'b1;
                dest = r16ie_pkg::LINK_REG;
                val  = pc4;
                npc  = {imm[13:0], 2'b00};
            end
            r16ie_pkg::OP_LW:
            begin
                wr   = 1'b1;
                ld_w = 1'b1;
            end
            r16ie_pkg::OP_SW:
            begin
                st_w = 1'b1;
            end
            r16ie_pkg::OP_J:
            begin
                npc = {imm[13:0], 2'b00};
            end
            r16ie_pkg::OP_NOR:
            begin
                wr   = 1'b1;
                dest = s1_reg.dst_c;
                val  = ~(op_a | op_b);
            end
            r16ie_pkg::OP_SLT:
            begin
                wr   = 1'b1;
                dest = s1_reg.dst_c;
                val  = {15'd0, ($signed(op_a) < $signed(op_b))};
            end
            r16ie_pkg::OP_SLL:
            begin
                wr   = 1'b1;
                dest = s1_reg.dst_c;
                val  = op_b << s1_reg.shift_amount;
            end
            r16ie_pkg::OP_SRA:
            begin
                wr   = 1'b1;
                dest = s1_reg.dst_c;
                val  = 16'($signed(op_b) >>> s1_reg.shift_amount);
            end
            r16ie_pkg::OP_JR:
            begin
                npc = op_a;
            end
            r16ie_pkg::OP_SRL:
            begin
                wr   = 1'b1;
                dest = s1_reg.dst_c;
                val  = op_b >> s1_reg.shift_amount;
            end
            r16ie_pkg::OP_OR:
            begin
                wr   = 1'b1;
                dest = s1_reg.dst_c;
                val  = op_a | op_b;
            end
            r16ie_pkg::OP_SUB:
            begin
                wr   = 1'b1;
                dest = s1_reg.dst_c;
                val  = op_a - op_b;
            end
            r16ie_pkg::OP_ADD:
            begin
                wr   = 1'b1;
                dest = s1_reg.dst_c;
                val  = op_a + op_b;
            end
            r16ie_pkg::OP_AND:
            begin
                wr   = 1'b1;
                dest = s1_reg.dst_c;
                val  = op_a & op_b;
            end
            r16ie_pkg::OP_SET_PC:
            begin
                npc = imm;
            end
            default:
            begin
                bad = 1'b1;
            end
        endcase

        // Drop writes to the zero register
        if (dest == r16ie_pkg::ZERO_REG)
        begin
            wr = 1'b0;
        end

        s2_next.ld_byte           = ld_b;
        s2_next.ld_word           = ld_w;
        s2_next.res.next_pc       = npc;
        s2_next.res.reg_written   = wr;
        s2_next.res.dest_index    = wr ? dest : r16ie_pkg::ZERO_REG;
        s2_next.res.written_value = wr ? val : '0;
        s2_next.res.bad_op        = bad;
        s2_next.res.halted        = (npc == '0);

        dmem_req.wr_byte = s1_valid_reg && st_b;
        dmem_req.wr_word = s1_valid_reg && st_w;
        dmem_req.addr    = addr[r16ie_pkg::MEM_ADDR_BITS-1:0];
        dmem_req.data    = op_b;
    end

    r16ie_dmem u_dmem (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (pipe_en),
        .req     (dmem_req),
        .rd_word (ld_word)
    );

    // Pipeline valids and pc
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            pc_reg       <= '0;
        end
        else if (pipe_en)
        begin
            s1_valid_reg <= in_fire;
            s2_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                pc_reg <= s2_next.res.next_pc;
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s1_reg <= r16ie_pkg::inst_t'(s_tdata);
            s2_reg <= s2_next;
        end
    end

    // Output register and skid: drain skid first, else take stage two
    assign out_take = !out_valid_reg || m_tready;
    assign s2_fire  = pipe_en && s2_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_take)
        begin
            out_valid_next  = skid_valid_reg || s2_fire;
            skid_valid_next = 1'b0;
        end
        else if (s2_fire)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : s2_res;
        end
        else if (s2_fire)
        begin
            skid_data_reg <= s2_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ sv/r16ie_ram.sv @@
// ----------------------------------------------------------------------------
// r16ie_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module r16ie_ram #(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port, data held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/r16ie_regfile.sv @@
// ----------------------------------------------------------------------------
// r16ie_regfile
// Two-read, one-write register file on two RAM copies with valid bits.
// ----------------------------------------------------------------------------
module r16ie_regfile (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               re,
    input  logic [r16ie_pkg::REG_IDX_W-1:0]    ra_idx,
    input  logic [r16ie_pkg::REG_IDX_W-1:0]    rb_idx,
    input  r16ie_pkg::rf_wr_t                  wr,
    input  logic                               cfg_we,
    input  logic [r16ie_pkg::DATA_W-1:0]       cfg_data,
    output logic [r16ie_pkg::DATA_W-1:0]       a_data,
    output logic [r16ie_pkg::DATA_W-1:0]       b_data
);

    logic [r16ie_pkg::REG_COUNT-1:0]    valid_reg;
    logic [r16ie_pkg::REG_COUNT-1:0]    valid_next;
    logic [r16ie_pkg::DATA_W-1:0]       stack_init_reg;
    r16ie_pkg::rf_wr_t                  last_wr_reg;
    r16ie_pkg::rf_wr_t                  last_wr_next;
    logic [r16ie_pkg::REG_IDX_W-1:0]    ra_idx_reg;
    logic [r16ie_pkg::REG_IDX_W-1:0]    rb_idx_reg;
    logic [r16ie_pkg::DATA_W-1:0]       ram_a;
    logic [r16ie_pkg::DATA_W-1:0]       ram_b;

    // Two copies keep both read ports independent
    r16ie_ram #(
        .WIDTH (r16ie_pkg::DATA_W),
        .DEPTH (r16ie_pkg::REG_COUNT)
    ) u_ram_a (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.idx),
        .wdata (wr.data),
        .re    (re),
        .raddr (ra_idx),
        .rdata (ram_a)
    );

    r16ie_ram #(
        .WIDTH (r16ie_pkg::DATA_W),
        .DEPTH (r16ie_pkg::REG_COUNT)
    ) u_ram_b (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.idx),
        .wdata (wr.data),
        .re    (re),
        .raddr (rb_idx),
        .rdata (ram_b)
    );

    // Resolve one read: same-edge write, then written entry, then reset value
    function automatic logic [r16ie_pkg::DATA_W-1:0] resolve(
        input logic [r16ie_pkg::REG_IDX_W-1:0] idx,
        input logic [r16ie_pkg::DATA_W-1:0]    ram_q,
        input r16ie_pkg::rf_wr_t               lw,
        input logic [r16ie_pkg::REG_COUNT-1:0] vld,
        input logic [r16ie_pkg::DATA_W-1:0]    sp_init
    );
        logic [r16ie_pkg::DATA_W-1:0] v;
        if (lw.en && (lw.idx == idx))
        begin
            v = lw.data;
        end
        else if (vld[idx])
        begin
            v = ram_q;
        end
        else if (idx == r16ie_pkg::SP_REG)
        begin
            v = sp_init;
        end
        else
        begin
            v = '0;
        end
        return v;
    endfunction

    assign a_data = resolve(ra_idx_reg, ram_a, last_wr_reg, valid_reg, stack_init_reg);
    assign b_data = resolve(rb_idx_reg, ram_b, last_wr_reg, valid_reg, stack_init_reg);

    // Mark written entries, drop the stack pointer entry on a config write
    always_comb
    begin
        valid_next   = valid_reg;
        last_wr_next = last_wr_reg;
        if (re)
        begin
            last_wr_next = wr;
        end
        if (wr.en)
        begin
            valid_next[wr.idx] = 1'b1;
        end
        if (cfg_we)
        begin
            valid_next[r16ie_pkg::SP_REG] = 1'b0;
            last_wr_next.en               = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            last_wr_reg    <= '0;
            stack_init_reg <= r16ie_pkg::STACK_INIT_RESET;
        end
        else
        begin
            valid_reg   <= valid_next;
            last_wr_reg <= last_wr_next;
            if (cfg_we)
            begin
                stack_init_reg <= cfg_data;
            end
        end
    end

    // Hold the read indices alongside the RAM data
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            ra_idx_reg <= ra_idx;
            rb_idx_reg <= rb_idx;
        end
    end

endmodule

@@ sv/r16ie_dmem.sv @@
// ----------------------------------------------------------------------------
// r16ie_dmem
// Byte-addressed data memory as even and odd byte banks, little-endian words.
// ----------------------------------------------------------------------------
module r16ie_dmem (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  r16ie_pkg::dmem_req_t          req,
    output logic [r16ie_pkg::DATA_W-1:0]  rd_word
);

    localparam int BANK_DEPTH = 2 ** (r16ie_pkg::MEM_ADDR_BITS - 1);
    localparam int BANK_AW    = r16ie_pkg::MEM_ADDR_BITS - 1;

    logic [BANK_AW-1:0] word_idx;
    logic [BANK_AW-1:0] word_idx_p1;
    logic               odd;
    logic               odd_reg;
    logic [BANK_AW-1:0] even_addr;
    logic               even_we;
    logic               odd_we;
    logic [7:0]         even_wdata;
    logic [7:0]         odd_wdata;
    logic [7:0]         even_rdata;
    logic [7:0]         odd_rdata;
    logic [7:0]         lo_byte;
    logic [7:0]         hi_byte;

    // Split the byte address into bank and word
    assign word_idx    = req.addr[r16ie_pkg::MEM_ADDR_BITS-1:1];
    assign word_idx_p1 = word_idx + BANK_AW'(1);
    assign odd         = req.addr[0];

    // An odd word puts its high byte in the next even entry
    assign even_addr = odd ? word_idx_p1 : word_idx;

    // Steer store bytes to the banks
    always_comb
    begin
        even_we    = en && ((req.wr_byte && !odd) || req.wr_word);
        odd_we     = en && ((req.wr_byte && odd) || req.wr_word);
        even_wdata = (odd && req.wr_word) ? req.data[15:8] : req.data[7:0];
        odd_wdata  = (odd || req.wr_byte) ? req.data[7:0] : req.data[15:8];
    end

    r16ie_ram #(
        .WIDTH (8),
        .DEPTH (BANK_DEPTH)
    ) u_even (
        .clk   (clk),
        .we    (even_we),
        .waddr (even_addr),
        .wdata (even_wdata),
        .re    (en),
        .raddr (even_addr),
        .rdata (even_rdata)
    );

    r16ie_ram #(
        .WIDTH (8),
        .DEPTH (BANK_DEPTH)
    ) u_odd (
        .clk   (clk),
        .we    (odd_we),
        .waddr (word_idx),
        .wdata (odd_wdata),
        .re    (en),
        .raddr (word_idx),
        .rdata (odd_rdata)
    );

    // Hold the byte lane of the read in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            odd_reg <= 1'b0;
        end
        else if (en)
        begin
            odd_reg <= odd;
        end
    end

    // Reassemble the word, low byte at the lower address
    assign lo_byte = odd_reg ? odd_rdata : even_rdata;
    assign hi_byte = odd_reg ? even_rdata : odd_rdata;
    assign rd_word = {hi_byte, lo_byte};

endmodule

@@ sv/r16ie_checker.sv @@
// ----------------------------------------------------------------------------
// r16ie_checker
// Port-level checks of the instruction executor result stream.
// ----------------------------------------------------------------------------
`include "risc16_instruction_executor_macros.svh"

module r16ie_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [r16ie_pkg::OUT_W-1:0]   m_tdata
);

    r16ie_pkg::res_t res;
    logic            out_stall;
    logic            pc_is_zero;
    logic            out_idle_wr;
    logic            wr_fields_zero;
    logic            out_wr;
    logic            out_bad;

    assign res            = r16ie_pkg::res_t'(m_tdata);
    assign out_stall      = m_tvalid && !m_tready;
    assign pc_is_zero     = (res.next_pc == '0);
    assign out_idle_wr    = m_tvalid && !res.reg_written;
    assign wr_fields_zero = (res.dest_index == '0) && (res.written_value == '0);
    assign out_wr         = m_tvalid && res.reg_written;
    assign out_bad        = m_tvalid && res.bad_op;

    // Stalled result beat holds
    `R16IE_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(m_tdata), "stalled beat moved")

    // Halt flag follows the returned pc
    `R16IE_ASSERT_NOW(a_halt_pc, m_tvalid, res.halted == pc_is_zero, "halt flag mismatch")

    // No write reported: index and value are zero
    `R16IE_ASSERT_NOW(a_no_wr_zero, out_idle_wr, wr_fields_zero, "idle write fields set")

    // A reported write never targets the zero register
    `R16IE_ASSERT_NOW(a_wr_nonzero, out_wr, res.dest_index != '0, "write to zero register")

    // Unknown operations write nothing
    `R16IE_ASSERT_NOW(a_bad_no_wr, out_bad, !res.reg_written, "bad op wrote a register")

endmodule

bind risc16_instruction_executor r16ie_checker u_r16ie_checker (.*);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the 16-bit RISC instruction executor. A shadow copy of the
// register file, pc and written data memory predicts each result beat. A short
// directed run covers edge values and every opcode. Random runs under several
// stack_init settings follow. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
import r16ie_pkg::*;

// Shadow of the executor state plus the queue of result beats still due
class core_shadow;
    logic [DATA_W-1:0] regs [REG_COUNT];
    logic [DATA_W-1:0] pc;
    logic [7:0]        mem [bit [15:0]];
    logic [15:0]       stored_addrs [$];
    res_t              due_results [$];
    int                mismatches;

    function new();
        foreach (regs[i])
            regs[i] = '0;
        regs[SP_REG] = STACK_INIT_RESET;
        pc           = '0;
        mismatches   = 0;
    endfunction

    function void set_stack(input logic [DATA_W-1:0] v);
        regs[SP_REG] = v;
    endfunction

    function logic [DATA_W-1:0] rd(input logic [REG_IDX_W-1:0] idx);
        return (idx == ZERO_REG) ? '0 : regs[idx];
    endfunction

    function void store(input logic [15:0] addr, input logic [7:0] v);
        if (!mem.exists(addr))
            stored_addrs.push_back(addr);
        mem[addr] = v;
    endfunction

    // Execute one accepted instruction and queue the result beat it causes
    function void note_instruction(input logic [IN_W-1:0] raw);
        inst_t                f;
        res_t                 r;
        logic [DATA_W-1:0]    a, b, imm, addr, npc, val;
        logic [REG_IDX_W-1:0] dest;
        logic                 wr, bad;
        f    = inst_t'(raw);
        a    = rd(f.src_a);
        b    = rd(f.src_b);
        imm  = f.imm_value;
        addr = a + imm;
        npc  = pc + PC_STEP;
        wr   = 1'b0;
        dest = ZERO_REG;
        val  = '0;
        bad  = 1'b0;
        case (f.op)
            OP_ORI:    begin wr = 1'b1; dest = f.src_b; val = a | imm; end
            OP_ADDI:   begin wr = 1'b1; dest = f.src_b; val = a + imm; end
            OP_BEQ:    if (a == b) npc = pc + (imm << 2) + PC_STEP;
            OP_BNE:    if (a != b) npc = pc + (imm << 2) + PC_STEP;
            OP_SB:     store(addr, b[7:0]);
            OP_LBU:    begin wr = 1'b1; dest = f.src_b; val = {8'h00, mem[addr]}; end
            OP_JAL:
            begin
                wr   = 1'b1;
                dest = LINK_REG;
                val  = pc + PC_STEP;
                npc  = imm << 2;
            end
            OP_LW:
            begin
                wr   = 1'b1;
                dest = f.src_b;
                val  = {mem[addr + 16'd1], mem[addr]};
            end
            OP_SW:
            begin
                store(addr, b[7:0]);
                store(addr + 16'd1, b[15:8]);
            end
            OP_J:      npc = imm << 2;
            OP_NOR:    begin wr = 1'b1; dest = f.dst_c; val = ~(a | b); end
            OP_SLT:
            begin
                wr   = 1'b1;
                dest = f.dst_c;
                val  = ($signed(a) < $signed(b)) ? 16'd1 : 16'd0;
            end
            OP_SLL:    begin wr = 1'b1; dest = f.dst_c; val = b << f.shift_amount; end
            OP_SRA:    begin wr = 1'b1; dest = f.dst_c; val = $signed(b) >>> f.shift_amount; end
            OP_JR:     npc = a;
            OP_SRL:    begin wr = 1'b1; dest = f.dst_c; val = b >> f.shift_amount; end
            OP_OR:     begin wr = 1'b1; dest = f.dst_c; val = a | b; end
            OP_SUB:    begin wr = 1'b1; dest = f.dst_c; val = a - b; end
            OP_ADD:    begin wr = 1'b1; dest = f.dst_c; val = a + b; end
            OP_AND:    begin wr = 1'b1; dest = f.dst_c; val = a & b; end
            OP_SET_PC: npc = imm;
            default:   bad = 1'b1;
        endcase
        // Drop writes to register zero
        if (wr && dest != ZERO_REG)
            regs[dest] = val;
        else
        begin
            wr   = 1'b0;
            dest = ZERO_REG;
            val  = '0;
        end
        pc              = npc;
        r.next_pc       = pc;
        r.reg_written   = wr;
        r.dest_index    = dest;
        r.written_value = val;
        r.bad_op        = bad;
        r.halted        = (pc == '0);
        due_results.push_back(r);
    endfunction

    task report(input string msg);
        mismatches++;
        $display("%0t ns mismatch: %s", $realtime, msg);
    endtask

    task cmp_field(input string name, input logic [15:0] got, input logic [15:0] want);
        if (got !== want)
            report($sformatf("%s got %h want %h", name, got, want));
    endtask

    // Compare one accepted result beat with the oldest one due
    task check_result(input logic [OUT_W-1:0] raw);
        res_t got, want;
        got = res_t'(raw);
        if (due_results.size() == 0)
        begin
            report($sformatf("result beat %h with nothing due", raw));
            return;
        end
        want = due_results.pop_front();
        cmp_field("next_pc", got.next_pc, want.next_pc);
        cmp_field("reg_written", 16'(got.reg_written), 16'(want.reg_written));
        cmp_field("dest_index", 16'(got.dest_index), 16'(want.dest_index));
        cmp_field("written_value", got.written_value, want.written_value);
        cmp_field("bad_op", 16'(got.bad_op), 16'(want.bad_op));
        cmp_field("halted", 16'(got.halted), 16'(want.halted));
    endtask
endclass

module tb_top;

    localparam logic [4:0] OP_CODE_MAX = 5'd31;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [DATA_W-1:0] cfg_data;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;

    core_shadow shadow;
    bit         steady;

    risc16_instruction_executor uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop if the run hangs
    initial
    begin
        #1000000;
        $display("tb_top: FAIL");
        $finish;
    end

    function automatic logic [IN_W-1:0] pack(
        input logic [4:0]  op,
        input logic [4:0]  ra,
        input logic [4:0]  rb,
        input logic [4:0]  rc,
        input logic [3:0]  sh,
        input logic [15:0] imm
    );
        return {imm, sh, rc, rb, ra, op};
    endfunction

    // Random instruction; loads are aimed at bytes already stored
    function automatic logic [IN_W-1:0] random_instruction();
        logic [4:0]  op, ra, rb, rc;
        logic [3:0]  sh;
        logic [15:0] imm, target;
        ra  = 5'($urandom_range(0, 31));
        rb  = 5'($urandom_range(0, 31));
        rc  = 5'($urandom_range(0, 31));
        sh  = 4'($urandom_range(0, 15));
        imm = 16'($urandom_range(0, 65535));
        op  = 5'($urandom_range(0, OP_SET_PC + 3));
        if (op > OP_SET_PC)
            op = 5'($urandom_range(OP_SET_PC + 1, OP_CODE_MAX));
        if ((op == OP_LBU || op == OP_LW) && shadow.stored_addrs.size() == 0)
            op = OP_SW;
        if (op == OP_LBU || op == OP_LW)
        begin
            target = shadow.stored_addrs[$urandom_range(0, shadow.stored_addrs.size() - 1)];
            if (!shadow.mem.exists(target + 16'd1))
                op = OP_LBU;
            imm = target - shadow.rd(ra);
        end
        if ((op == OP_J || op == OP_SET_PC) && $urandom_range(0, 7) == 0)
            imm = '0;
        return pack(op, ra, rb, rc, sh, imm);
    endfunction

    // Present one instruction beat after a random gap and wait for acceptance
    task automatic send(input logic [IN_W-1:0] beat);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        do @(posedge clk); while (!s_tready);
        shadow.note_instruction(beat);
    endtask

    // Drop valid and hold until every due result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (shadow.due_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_stack_init(input logic [DATA_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        shadow.set_stack(v);
    endtask

    // Result side: stall at random, check each accepted beat
    initial
    begin : result_sink
        int stall;
        m_tready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            shadow.check_result(m_tdata);
        end
    end

    initial
    begin : run
        logic [DATA_W-1:0] stack_values [4];
        shadow    = new();
        steady    = 1'b0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed run with the stack pointer at its top value
        write_stack_init(16'hFFFF);
        send(pack(OP_ORI, 0, 1, 0, 0, 16'hFFFF));
        send(pack(OP_ADDI, 0, 2, 0, 0, 16'h7FFF));
        send(pack(OP_ADDI, 1, 3, 0, 0, 16'h8001));
        // write to register zero is discarded
        send(pack(OP_ADDI, 1, 0, 0, 0, 16'h0001));
        // word at the top address wraps its high byte to address zero
        send(pack(OP_SW, 0, 3, 0, 0, 16'hFFFF));
        send(pack(OP_LW, 0, 4, 0, 0, 16'hFFFF));
        send(pack(OP_SB, 29, 2, 0, 0, 16'h0011));
        send(pack(OP_LBU, 29, 5, 0, 0, 16'h0011));
        send(pack(OP_NOR, 2, 3, 6, 0, 16'h0000));
        send(pack(OP_SLT, 2, 3, 7, 0, 16'h0000));
        send(pack(OP_SLT, 3, 2, 8, 0, 16'h0000));
        send(pack(OP_SLL, 0, 1, 9, 15, 16'h0000));
        send(pack(OP_SRA, 0, 3, 10, 15, 16'h0000));
        send(pack(OP_SRL, 0, 3, 11, 15, 16'h0000));
        send(pack(OP_OR, 2, 3, 12, 0, 16'h0000));
        send(pack(OP_SUB, 0, 2, 13, 0, 16'h0000));
        send(pack(OP_ADD, 29, 1, 14, 0, 16'h0000));
        send(pack(OP_AND, 1, 3, 31, 0, 16'h0000));
        send(pack(OP_BEQ, 0, 0, 0, 0, 16'hFFFF));
        send(pack(OP_BNE, 2, 2, 0, 0, 16'h7FFF));
        send(pack(OP_BNE, 2, 3, 0, 0, 16'h8000));
        send(pack(OP_JAL, 0, 0, 0, 0, 16'h3FFF));
        send(pack(OP_JR, 1, 0, 0, 0, 16'h0000));
        send(pack(OP_J, 0, 0, 0, 0, 16'h0000));
        send(pack(OP_SET_PC, 0, 0, 0, 0, 16'hFFFC));
        // unknown opcodes: pc advance only, wrapping to zero here
        send(pack(OP_CODE_MAX, 0, 0, 0, 0, 16'h0000));
        send(pack(5'(OP_SET_PC + 1), 31, 31, 31, 15, 16'hFFFF));
        drain();

        // Random runs, one per stack_init setting
        stack_values = '{16'h0000, 16'($urandom_range(1, 65534)), 16'hFFFF, STACK_INIT_RESET};
        foreach (stack_values[k])
        begin
            write_stack_init(stack_values[k]);
            for (int n = 0; n < 100; n++)
            begin
                if (n % 25 == 0)
                    steady = ($urandom_range(0, 3) == 0);
                send(random_instruction());
            end
            drain();
        end

        if (shadow.mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/r16ie_pkg.sv
sv/r16ie_ram.sv
sv/r16ie_regfile.sv
sv/r16ie_dmem.sv
sv/risc16_instruction_executor.sv
sv/r16ie_checker.sv
tb/sv/tb_top.sv
